// ===== hdl/ptwdc_pkg.sv =====
// Shared types and constants for the per-type window detection confirm core.
// Holds request/event payload structs, config register codes and sizing.
// No dependencies.
package ptwdc_pkg;

  // Sizing of the history store
  localparam int NUM_TYPES  = 16;
  localparam int MAX_WINDOW = 32;
  localparam int TYPE_AW    = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
  localparam int CNT_W      = $clog2(MAX_WINDOW + 1);

  // Field widths
  localparam int TYPE_W = 4;
  localparam int TIME_W = 63;
  localparam int CAM_W  = 8;
  localparam int CFG_W  = 6;
  localparam int CFG_IDX_W = 2;

  // Config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_POS    = 2'd2;

  // Reset values of the config registers
  localparam logic [CFG_W-1:0] WINDOW_LEN_RST = 6'd3;
  localparam logic [CFG_W-1:0] MIN_POS_RST    = 6'd2;

  // Count saturation limit
  localparam logic [CFG_W-1:0] COUNT_SAT = 6'd63;

  // One detection request
  typedef struct packed {
    logic [TYPE_W-1:0] event_type;
    logic              detected;
    logic [TIME_W-1:0] mono_time_ns;
    logic [TIME_W-1:0] wall_time_ms;
    logic [CAM_W-1:0]  camera_number;
  } det_req_t;

  // One result request
  typedef struct packed {
    logic              confirmed;
    logic [CFG_W-1:0]  positive_count;
    logic [TYPE_W-1:0] out_type;
    logic [TIME_W-1:0] out_mono_ns;
    logic [TIME_W-1:0] out_real_ms;
    logic [CAM_W-1:0]  out_camera;
  } evt_t;

  // Result of one history update
  typedef struct packed {
    logic [MAX_WINDOW-1:0] hist;
    logic [CFG_W-1:0]      count;
    logic                  hit;
  } upd_t;

endpackage

// ===== hdl/ptwdc_update.sv =====
// History update for one type: shift in the new result, cut to the window,
// count positives and decide confirmation. Depends on ptwdc_pkg.
module ptwdc_update (
  input  logic [ptwdc_pkg::MAX_WINDOW-1:0] hist_in,
  input  logic                             detected,
  input  logic [ptwdc_pkg::CFG_W-1:0]      window_length,
  input  logic [ptwdc_pkg::CFG_W-1:0]      min_positives,
  output ptwdc_pkg::upd_t                  upd
);

  logic [ptwdc_pkg::CFG_W:0]        win;
  logic [ptwdc_pkg::CFG_W:0]        wl_ext;
  logic [ptwdc_pkg::CFG_W-1:0]      minp;
  logic [ptwdc_pkg::MAX_WINDOW-1:0] mask;
  logic [ptwdc_pkg::MAX_WINDOW-1:0] hist_new;
  logic [ptwdc_pkg::CNT_W-1:0]      raw_cnt;
  logic [ptwdc_pkg::CFG_W-1:0]      cnt;

  // Clamp window to 1..MAX_WINDOW and minimum to at least 1
  always_comb begin
    wl_ext = {1'b0, window_length};
    if (window_length == '0) begin
      win = (ptwdc_pkg::CFG_W + 1)'(1);
    end else if (wl_ext > (ptwdc_pkg::CFG_W + 1)'(ptwdc_pkg::MAX_WINDOW)) begin
      win = (ptwdc_pkg::CFG_W + 1)'(ptwdc_pkg::MAX_WINDOW);
    end else begin
      win = wl_ext;
    end
    minp = (min_positives == '0) ? ptwdc_pkg::CFG_W'(1) : min_positives;
  end

  // Build the window mask
  always_comb begin
    for (int i = 0; i < ptwdc_pkg::MAX_WINDOW; i++) begin
      mask[i] = ((ptwdc_pkg::CFG_W + 1)'(i) < win);
    end
  end

  // Shift in the newest result and count positives
  always_comb begin
    hist_new = ((hist_in << 1) | ptwdc_pkg::MAX_WINDOW'(detected)) & mask;
    raw_cnt  = ptwdc_pkg::CNT_W'($countones(hist_new));
    if (ptwdc_pkg::CFG_W'(raw_cnt) != ptwdc_pkg::COUNT_SAT &&
        raw_cnt > ptwdc_pkg::CNT_W'(ptwdc_pkg::COUNT_SAT)) begin
      cnt = ptwdc_pkg::COUNT_SAT;
    end else begin
      cnt = ptwdc_pkg::CFG_W'(raw_cnt);
    end
    upd.hist  = hist_new;
    upd.count = cnt;
    upd.hit   = detected && (cnt >= minp);
  end

endmodule

// ===== hdl/per_type_window_detection_confirm_core.sv =====
// Top level of the per-type window detection confirm core.
// Depends on ptwdc_pkg and ptwdc_update.
//
// Takes one detection request per clock while det_stall is low and
// returns exactly one result request for each; the request passes through
// the stage 1 registers and then the output register, which holds the
// result until the consumer takes it. The per-type history lives in a
// 16 x 32 synchronous RAM: the read is issued as the request is accepted,
// the updated history is written back as stage 1 advances, and a
// back-to-back request of the same type picks up the written value
// through a forwarding register. A valid bit per entry makes never-written
// histories read as empty, so no clearing pass runs after reset.
// Throughput is one request per clock while the consumer does not stall;
// the output register lets a new request enter while a result waits.
module per_type_window_detection_confirm_core (
  input  logic                               clk,
  input  logic                               rst,
  // Detection request channel
  input  logic                               det_valid,
  output logic                               det_stall,
  input  ptwdc_pkg::det_req_t                det,
  // Result request channel
  output logic                               evt_valid,
  input  logic                               evt_stall,
  output ptwdc_pkg::evt_t                    evt,
  // Config write port
  input  logic                               cfg_we,
  input  logic [ptwdc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ptwdc_pkg::CFG_W-1:0]        cfg_data
);

  // Config registers
  logic                         enable;
  logic [ptwdc_pkg::CFG_W-1:0]  window_length;
  logic [ptwdc_pkg::CFG_W-1:0]  min_positives;

  // History RAM and entry valid bits
  logic [ptwdc_pkg::MAX_WINDOW-1:0] hist_mem [ptwdc_pkg::NUM_TYPES];
  logic [ptwdc_pkg::MAX_WINDOW-1:0] rd_data;
  logic [ptwdc_pkg::NUM_TYPES-1:0]  hist_vld;

  // Stage 1 registers
  logic                             s1_valid;
  ptwdc_pkg::det_req_t              s1_req;
  logic                             s1_in_range;
  logic                             s1_vld_bit;
  logic                             s1_fwd;
  logic [ptwdc_pkg::MAX_WINDOW-1:0] fwd_hist;

  // Control
  logic                             det_accept;
  logic                             s1_advance;
  logic                             s1_active;
  logic                             wr_en;
  logic                             in_range;
  logic [ptwdc_pkg::TYPE_AW-1:0]    in_addr;
  logic [ptwdc_pkg::TYPE_AW-1:0]    s1_addr;
  logic [ptwdc_pkg::MAX_WINDOW-1:0] hist_cur;
  ptwdc_pkg::upd_t                  upd;
  ptwdc_pkg::evt_t                  evt_next;

  // Write config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enable        <= 1'b0;
      window_length <= ptwdc_pkg::WINDOW_LEN_RST;
      min_positives <= ptwdc_pkg::MIN_POS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ptwdc_pkg::CFG_ENABLE:     enable        <= cfg_data[0];
        ptwdc_pkg::CFG_WINDOW_LEN: window_length <= cfg_data;
        ptwdc_pkg::CFG_MIN_POS:    min_positives <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake and address decode
  always_comb begin
    s1_advance = s1_valid && (!evt_valid || !evt_stall);
    det_stall  = s1_valid && !s1_advance;
    det_accept = det_valid && !det_stall;
    in_range   = ({3'b000, det.event_type} < 7'(ptwdc_pkg::NUM_TYPES));
    in_addr    = ptwdc_pkg::TYPE_AW'(det.event_type);
    s1_addr    = ptwdc_pkg::TYPE_AW'(s1_req.event_type);
    s1_active  = enable && s1_in_range;
    wr_en      = s1_advance && s1_active;
  end

  // Read on accept, write back on stage 1 advance while enabled
  always_ff @(posedge clk) begin
    if (det_accept) begin
      rd_data <= hist_mem[in_addr];
    end
    if (wr_en) begin
      hist_mem[s1_addr] <= upd.hist;
    end
  end

  // Mark entries as written
  always_ff @(posedge clk) begin
    if (rst) begin
      hist_vld <= '0;
    end else if (wr_en) begin
      hist_vld[s1_addr] <= 1'b1;
    end
  end

  // Advance the request into stage 1 and capture forwarding
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (det_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (det_accept) begin
      s1_req      <= det;
      s1_in_range <= in_range;
      s1_vld_bit  <= hist_vld[in_addr];
      s1_fwd      <= wr_en && (s1_addr == in_addr);
      fwd_hist    <= upd.hist;
    end
  end

  // Select the current history: forwarded, stored, or empty
  always_comb begin
    if (s1_fwd) begin
      hist_cur = fwd_hist;
    end else if (s1_vld_bit) begin
      hist_cur = rd_data;
    end else begin
      hist_cur = '0;
    end
  end

  ptwdc_update u_update (
    .hist_in       (hist_cur),
    .detected      (s1_req.detected),
    .window_length (window_length),
    .min_positives (min_positives),
    .upd           (upd)
  );

  // Build the result
  always_comb begin
    evt_next = '0;
    if (s1_active) begin
      evt_next.positive_count = upd.count;
      if (upd.hit) begin
        evt_next.confirmed   = 1'b1;
        evt_next.out_type    = s1_req.event_type;
        evt_next.out_mono_ns = s1_req.mono_time_ns;
        evt_next.out_real_ms = s1_req.wall_time_ms;
        evt_next.out_camera  = s1_req.camera_number;
      end
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      evt_valid <= 1'b0;
    end else if (s1_advance) begin
      evt_valid <= 1'b1;
    end else if (!evt_stall) begin
      evt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      evt <= evt_next;
    end
  end

endmodule
